// ----- sv/wrs_pkg.sv -----
package wrs_pkg;

  localparam int OFF_W      = 48;
  localparam int NODE_W     = 64;
  localparam int SHIFT_W    = 5;
  localparam int MBPR_W     = 17;
  localparam int WIN_W      = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_BLOCKS = 65536;
  localparam int MAX_WINDOW = 32;
  localparam int RESET_MBPR = 1024;
  localparam int RESET_WIN  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INFLIGHT = 8'd1;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DONE  = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [1:0] KIND_SUB    = 2'd0;
  localparam logic [1:0] KIND_NOTICE = 2'd1;
  localparam logic [1:0] KIND_REPLY  = 2'd2;

  typedef enum logic [1:0] {
    OP_START,
    OP_DONE,
    OP_ABORT
  } cmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_EVAL,
    ST_CMP,
    ST_EMIT,
    ST_NOTICE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [NODE_W-1:0]  node_id;
    logic [OFF_W-1:0]   range_offset;
    logic [OFF_W-1:0]   range_length;
    logic [SHIFT_W-1:0] block_shift;
    logic               reply_to_caller;
  } item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] out_node_id;
    logic [OFF_W-1:0]  sub_offset;
    logic [OFF_W-1:0]  sub_length;
    logic              last;
  } result_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [NODE_W-1:0]  node;
    logic [OFF_W-1:0]   offset;
    logic [OFF_W-1:0]   end_off;
    logic [SHIFT_W-1:0] shift;
    logic               reply;
    logic               go;
  } cmd_t;

endpackage

// ----- sv/wrs_front.sv -----
module wrs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  wrs_pkg::item_t item,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output wrs_pkg::cmd_t  cmd
);

  wrs_pkg::cmd_t               q [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic [wrs_pkg::OFF_W:0]     sum;
  wrs_pkg::cmd_t               cls;
  logic                        enq;
  logic                        deq;

  always_comb begin
    sum         = {1'b0, item.range_offset} + {1'b0, item.range_length};
    cls.node    = item.node_id;
    cls.offset  = item.range_offset;
    cls.end_off = sum[wrs_pkg::OFF_W] ? {wrs_pkg::OFF_W{1'b1}} : sum[wrs_pkg::OFF_W-1:0];
    cls.shift   = item.block_shift;
    cls.reply   = item.reply_to_caller;
    cls.go      = (item.range_length != '0) && !(&item.range_offset);
    case (item.action)
      wrs_pkg::ACT_START: cls.op = wrs_pkg::OP_START;
      wrs_pkg::ACT_DONE:  cls.op = wrs_pkg::OP_DONE;
      default:            cls.op = wrs_pkg::OP_ABORT;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign enq       = push && !full && (item.action != wrs_pkg::ACT_SPARE);
  assign deq       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cls;
    end
  end

endmodule

// ----- sv/wrs_back.sv -----
module wrs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  wrs_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [wrs_pkg::MBPR_W-1:0]    max_blocks,
  input  logic [wrs_pkg::WIN_W-1:0]     max_inflight,
  input  logic                          res_full,
  output logic                          res_push,
  output wrs_pkg::result_t              res
);

  wrs_pkg::state_t              state;
  wrs_pkg::state_t              state_next;
  logic                         busy;
  logic                         more;
  logic [wrs_pkg::WIN_W-1:0]    outstanding;
  logic [wrs_pkg::WIN_W-1:0]    win_m1;
  logic [wrs_pkg::OFF_W-1:0]    next_off;
  logic [wrs_pkg::OFF_W-1:0]    end_off;
  logic [wrs_pkg::NODE_W-1:0]   job_node;
  logic [wrs_pkg::SHIFT_W-1:0]  job_shift;
  logic                         job_reply;
  logic [wrs_pkg::OFF_W-1:0]    stripe;
  logic [wrs_pkg::OFF_W-1:0]    mask;
  logic [wrs_pkg::OFF_W-1:0]    rem;
  logic [wrs_pkg::OFF_W-1:0]    sum;
  logic                         rem_le;
  logic [wrs_pkg::OFF_W-1:0]    cut;
  logic [wrs_pkg::OFF_W-1:0]    cut_len;
  logic [wrs_pkg::MBPR_W-1:0]   blocks_cl;
  logic [wrs_pkg::WIN_W-1:0]    win_cl;
  logic                         can_issue;
  logic                         sub_last;

  always_comb begin
    if (max_blocks == '0) begin
      blocks_cl = wrs_pkg::MBPR_W'(1);
    end else if (max_blocks > wrs_pkg::MBPR_W'(wrs_pkg::MAX_BLOCKS)) begin
      blocks_cl = wrs_pkg::MBPR_W'(wrs_pkg::MAX_BLOCKS);
    end else begin
      blocks_cl = max_blocks;
    end
    if (max_inflight == '0) begin
      win_cl = wrs_pkg::WIN_W'(1);
    end else if (max_inflight > wrs_pkg::WIN_W'(wrs_pkg::MAX_WINDOW)) begin
      win_cl = wrs_pkg::WIN_W'(wrs_pkg::MAX_WINDOW);
    end else begin
      win_cl = max_inflight;
    end
  end

  assign can_issue = more && (outstanding <= win_m1);
  assign sub_last  = rem_le || (outstanding >= win_m1);

  always_comb begin
    state_next = state;
    case (state)
      wrs_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            wrs_pkg::OP_START: state_next = cmd.go ? wrs_pkg::ST_PREP : wrs_pkg::ST_IDLE;
            wrs_pkg::OP_DONE: begin
              state_next = (busy && outstanding != '0) ? wrs_pkg::ST_PREP : wrs_pkg::ST_IDLE;
            end
            default: state_next = wrs_pkg::ST_IDLE;
          endcase
        end
      end
      wrs_pkg::ST_PREP: state_next = wrs_pkg::ST_EVAL;
      wrs_pkg::ST_EVAL: begin
        if (can_issue) begin
          state_next = wrs_pkg::ST_CMP;
        end else if (outstanding == '0) begin
          state_next = wrs_pkg::ST_NOTICE;
        end else begin
          state_next = wrs_pkg::ST_IDLE;
        end
      end
      wrs_pkg::ST_CMP: state_next = wrs_pkg::ST_EMIT;
      wrs_pkg::ST_EMIT: begin
        if (!res_full) begin
          state_next = sub_last ? wrs_pkg::ST_IDLE : wrs_pkg::ST_EVAL;
        end
      end
      wrs_pkg::ST_NOTICE: begin
        if (!res_full) begin
          state_next = job_reply ? wrs_pkg::ST_REPLY : wrs_pkg::ST_IDLE;
        end
      end
      wrs_pkg::ST_REPLY: begin
        if (!res_full) begin
          state_next = wrs_pkg::ST_IDLE;
        end
      end
      default: state_next = wrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res.kind        = wrs_pkg::KIND_SUB;
    res.out_node_id = job_node;
    res.sub_offset  = '0;
    res.sub_length  = '0;
    res.last        = 1'b0;
    case (state)
      wrs_pkg::ST_IDLE: cmd_pop = cmd_valid;
      wrs_pkg::ST_EMIT: begin
        res_push       = !res_full;
        res.sub_offset = next_off;
        res.sub_length = rem_le ? rem : cut_len;
        res.last       = sub_last;
      end
      wrs_pkg::ST_NOTICE: begin
        res_push = !res_full;
        res.kind = wrs_pkg::KIND_NOTICE;
        res.last = !job_reply;
      end
      wrs_pkg::ST_REPLY: begin
        res_push = !res_full;
        res.kind = wrs_pkg::KIND_REPLY;
        res.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wrs_pkg::ST_IDLE;
      busy        <= 1'b0;
      more        <= 1'b0;
      outstanding <= '0;
      next_off    <= '0;
      end_off     <= '0;
      job_node    <= '0;
      job_shift   <= '0;
      job_reply   <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        wrs_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              wrs_pkg::OP_START: begin
                busy        <= cmd.go;
                more        <= cmd.go;
                outstanding <= '0;
                next_off    <= cmd.offset;
                end_off     <= cmd.end_off;
                job_node    <= cmd.node;
                job_shift   <= cmd.shift;
                job_reply   <= cmd.reply;
              end
              wrs_pkg::OP_DONE: begin
                if (busy && outstanding != '0) begin
                  outstanding <= outstanding - 1'b1;
                end
              end
              default: begin
                busy        <= 1'b0;
                more        <= 1'b0;
                outstanding <= '0;
                next_off    <= '0;
                end_off     <= '0;
              end
            endcase
          end
        end
        wrs_pkg::ST_EMIT: begin
          if (!res_full) begin
            next_off    <= rem_le ? end_off : cut;
            more        <= !rem_le;
            outstanding <= outstanding + 1'b1;
          end
        end
        wrs_pkg::ST_NOTICE: begin
          if (!res_full) begin
            busy <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      wrs_pkg::ST_PREP: begin
        stripe <= wrs_pkg::OFF_W'(blocks_cl) << job_shift;
        mask   <= {wrs_pkg::OFF_W{1'b1}} << job_shift;
        win_m1 <= win_cl - 1'b1;
      end
      wrs_pkg::ST_EVAL: begin
        rem <= end_off - next_off;
        sum <= next_off + stripe;
      end
      wrs_pkg::ST_CMP: begin
        rem_le  <= (rem <= stripe);
        cut     <= sum & mask;
        cut_len <= (sum & mask) - next_off;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/wrs_outq.sv -----
module wrs_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  output logic             res_full,
  input  wrs_pkg::result_t res,
  output logic             empty,
  input  logic             pop,
  output wrs_pkg::result_t result
);

  wrs_pkg::result_t q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             enq;
  logic             deq;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign result   = q[rd_ptr];
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= res;
    end
  end

endmodule

// ----- sv/windowed_range_splitter.sv -----
// The back sequencer pops each command in its idle state and sets up a start, or a
// completion it waits for, in its prep state; each sub-request it issues passes eval,
// cmp and emit, and a pass that issues nothing leaves from eval. A completion
// notice and a caller reply take a state each, and a full result queue stalls it.
// The front queue holds 2 commands and the result queue 2 words.
// Synchronous active-high reset empties both queues, clears the job state and loads
// the register defaults (1024 blocks per sub-request, window of 10).
module windowed_range_splitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  wrs_pkg::item_t                   item,
  output logic                             empty,
  input  logic                             pop,
  output wrs_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [wrs_pkg::MBPR_W-1:0] max_blocks;
  logic [wrs_pkg::WIN_W-1:0]  max_inflight;
  logic                       cmd_valid;
  logic                       cmd_pop;
  wrs_pkg::cmd_t              cmd;
  logic                       res_full;
  logic                       res_push;
  wrs_pkg::result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks   <= wrs_pkg::MBPR_W'(wrs_pkg::RESET_MBPR);
      max_inflight <= wrs_pkg::WIN_W'(wrs_pkg::RESET_WIN);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wrs_pkg::REG_MAX_BLOCKS:   max_blocks   <= cfg_data[wrs_pkg::MBPR_W-1:0];
        wrs_pkg::REG_MAX_INFLIGHT: max_inflight <= cfg_data[wrs_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  wrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  wrs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .max_blocks   (max_blocks),
    .max_inflight (max_inflight),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res)
  );

  wrs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule

// ----- sv/wrs_checker.sv -----
module wrs_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input wrs_pkg::result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result word changed");

  a_sub_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == wrs_pkg::KIND_SUB |-> result.sub_length != '0)
    else $error("sub-request of zero length");

  a_notice_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind != wrs_pkg::KIND_SUB |->
      result.sub_offset == '0 && result.sub_length == '0)
    else $error("notice or reply carries a range");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.kind == wrs_pkg::KIND_REPLY |-> result.last)
    else $error("caller reply not marked last");

endmodule

bind windowed_range_splitter wrs_checker u_chk (.*);

// ----- sim/split_checker.sv -----
module split_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  input  logic                                    full,
  input  wrs_pkg::item_t                          item,
  input  logic                                    empty,
  input  logic                                    pop,
  input  wrs_pkg::result_t                        result,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]          cfg_data,
  output int                                      fail_count,
  output int                                      words_pending
);

  localparam logic [63:0] OFF_MASK = {{(64-wrs_pkg::OFF_W){1'b0}}, {wrs_pkg::OFF_W{1'b1}}};
  localparam int STEP_CAP = 32;

  logic [wrs_pkg::MBPR_W-1:0]  blocks_reg = wrs_pkg::MBPR_W'(wrs_pkg::RESET_MBPR);
  logic [wrs_pkg::WIN_W-1:0]   window_reg = wrs_pkg::WIN_W'(wrs_pkg::RESET_WIN);
  logic                        job_busy = 1'b0;
  logic [63:0]                 next_off = '0;
  logic [63:0]                 end_off = '0;
  int unsigned                 in_flight = 0;
  logic [wrs_pkg::NODE_W-1:0]  job_node = '0;
  logic [wrs_pkg::SHIFT_W-1:0] job_shift = '0;
  logic                        job_reply = 1'b0;
  int                          step_words = 0;
  int                          mismatches = 0;
  wrs_pkg::result_t            expected_words[$];
  wrs_pkg::result_t            want;

  initial begin
    fail_count = 0;
    words_pending = 0;
  end

  function automatic void add_word(logic [1:0] kind, logic [63:0] off, logic [63:0] len);
    wrs_pkg::result_t w;
    w.kind = kind;
    w.out_node_id = job_node;
    w.sub_offset = off[wrs_pkg::OFF_W-1:0];
    w.sub_length = len[wrs_pkg::OFF_W-1:0];
    w.last = 1'b0;
    expected_words.push_back(w);
    step_words++;
  endfunction

  // Cuts the range from next_off onward while credits remain in the window.
  function automatic void issue_subs();
    logic [63:0] blocks;
    logic [63:0] stripe;
    logic [63:0] bsize;
    logic [63:0] cut;
    int unsigned win_cap;
    blocks = 64'(blocks_reg);
    if (blocks < 64'd1) blocks = 64'd1;
    if (blocks > 64'(wrs_pkg::MAX_BLOCKS)) blocks = 64'(wrs_pkg::MAX_BLOCKS);
    win_cap = 32'(window_reg);
    if (win_cap < 1) win_cap = 1;
    if (win_cap > wrs_pkg::MAX_WINDOW) win_cap = wrs_pkg::MAX_WINDOW;
    stripe = blocks << job_shift;
    bsize = 64'd1 << job_shift;
    while (next_off < end_off && in_flight < win_cap && step_words < STEP_CAP) begin
      if (end_off - next_off <= stripe) cut = end_off;
      else cut = (next_off + stripe) & ~(bsize - 64'd1);
      add_word(wrs_pkg::KIND_SUB, next_off, cut - next_off);
      next_off = cut;
      in_flight++;
    end
  endfunction

  function automatic void predict_item(wrs_pkg::item_t w);
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] stop;
    wrs_pkg::result_t tail;
    step_words = 0;
    case (w.action)
      wrs_pkg::ACT_START: begin
        off = 64'(w.range_offset);
        len = 64'(w.range_length);
        stop = off + len;
        if (stop > OFF_MASK) stop = OFF_MASK;
        job_busy = 1'b0;
        in_flight = 0;
        job_node = w.node_id;
        job_shift = w.block_shift;
        job_reply = w.reply_to_caller;
        next_off = off;
        end_off = stop;
        if (len != 0 && stop > off) begin
          job_busy = 1'b1;
          issue_subs();
        end
      end
      wrs_pkg::ACT_DONE: begin
        if (job_busy && in_flight > 0) begin
          in_flight--;
          issue_subs();
          if (in_flight == 0) begin
            add_word(wrs_pkg::KIND_NOTICE, '0, '0);
            if (job_reply) add_word(wrs_pkg::KIND_REPLY, '0, '0);
            job_busy = 1'b0;
          end
        end
      end
      wrs_pkg::ACT_ABORT: begin
        job_busy = 1'b0;
        in_flight = 0;
        next_off = '0;
        end_off = '0;
      end
      default: ;
    endcase
    if (step_words > 0) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  function automatic void flag_word(string what, wrs_pkg::result_t exp_w);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected kind %0d node %h off %h len %h last %b", what,
               exp_w.kind, exp_w.out_node_id, exp_w.sub_offset, exp_w.sub_length, exp_w.last);
      $display("%s: actual   kind %0d node %h off %h len %h last %b", what,
               result.kind, result.out_node_id, result.sub_offset, result.sub_length,
               result.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blocks_reg = wrs_pkg::MBPR_W'(wrs_pkg::RESET_MBPR);
      window_reg = wrs_pkg::WIN_W'(wrs_pkg::RESET_WIN);
      job_busy = 1'b0;
      next_off = '0;
      end_off = '0;
      in_flight = 0;
      job_node = '0;
      job_shift = '0;
      job_reply = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wrs_pkg::REG_MAX_BLOCKS) begin
          blocks_reg = cfg_data[wrs_pkg::MBPR_W-1:0];
        end else if (cfg_index == wrs_pkg::REG_MAX_INFLIGHT) begin
          window_reg = cfg_data[wrs_pkg::WIN_W-1:0];
        end
      end
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          flag_word("unexpected word", '0);
        end else begin
          want = expected_words.pop_front();
          if (result.kind !== want.kind || result.out_node_id !== want.out_node_id ||
              result.sub_offset !== want.sub_offset ||
              result.sub_length !== want.sub_length || result.last !== want.last) begin
            flag_word("wrong word", want);
          end
        end
      end
      if (push && !full) predict_item(item);
    end
    fail_count <= mismatches;
    words_pending <= expected_words.size();
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

  localparam logic [63:0] OFF_LIMIT = {{(64-wrs_pkg::OFF_W){1'b0}}, {wrs_pkg::OFF_W{1'b1}}};
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  wrs_pkg::item_t                 item = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  wrs_pkg::result_t               result;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [wrs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wrs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic squeeze = 1'b0;
  logic squeezed = 1'b0;
  int   fail_count;
  int   words_pending;
  int   cycle_count = 0;
  int   hold_left = 0;
  int   pop_mode = 0;
  int   mode_left = 0;
  int   burst_left = 0;
  int   cur_blocks = wrs_pkg::RESET_MBPR;
  int   cur_win = wrs_pkg::RESET_WIN;

  windowed_range_splitter dut (.*);

  split_checker watch (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .words_pending(words_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls on a pattern that is redrawn at random, and once
  // stops taking words for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (squeeze && !squeezed) begin
      pop <= 1'b0;
      squeezed <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (mode_left == 0) begin
        pop_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic wrs_pkg::item_t make_word(logic [1:0] act,
                                               logic [wrs_pkg::NODE_W-1:0] node,
                                               logic [wrs_pkg::OFF_W-1:0] off,
                                               logic [wrs_pkg::OFF_W-1:0] len,
                                               logic [wrs_pkg::SHIFT_W-1:0] shift,
                                               logic reply);
    wrs_pkg::item_t w;
    w.action = act;
    w.node_id = node;
    w.range_offset = off;
    w.range_length = len;
    w.block_shift = shift;
    w.reply_to_caller = reply;
    return w;
  endfunction

  function automatic wrs_pkg::item_t random_word();
    return make_word(wrs_pkg::ACT_START, {$urandom, $urandom}, 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}), 5'($urandom), 1'($urandom));
  endfunction

  task automatic send_word(input wrs_pkg::item_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    push <= 1'b1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic write_reg(input logic [wrs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wrs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_setting(input logic [wrs_pkg::CFG_DATA_W-1:0] blocks_data,
                               input logic [wrs_pkg::CFG_DATA_W-1:0] win_data);
    write_reg(8'($urandom_range(wrs_pkg::REG_MAX_INFLIGHT + 1, 255)), $urandom);
    write_reg(wrs_pkg::REG_MAX_BLOCKS, blocks_data);
    write_reg(wrs_pkg::REG_MAX_INFLIGHT, win_data);
    cfg_valid <= 1'b0;
    cur_blocks = int'(blocks_data[wrs_pkg::MBPR_W-1:0]);
    if (cur_blocks < 1) cur_blocks = 1;
    if (cur_blocks > wrs_pkg::MAX_BLOCKS) cur_blocks = wrs_pkg::MAX_BLOCKS;
    cur_win = int'(win_data[wrs_pkg::WIN_W-1:0]);
    if (cur_win < 1) cur_win = 1;
    if (cur_win > wrs_pkg::MAX_WINDOW) cur_win = wrs_pkg::MAX_WINDOW;
  endtask

  // Ends a phase with an abort so that no job spans a register change.
  task automatic close_phase();
    wrs_pkg::item_t w;
    w = random_word();
    w.action = wrs_pkg::ACT_ABORT;
    send_word(w);
    push <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly whole jobs: a start sized to a few stripes followed by about as many
  // completions as it needs. The rest is noise and jobs cut short.
  task automatic random_jobs(input int count);
    wrs_pkg::item_t w;
    logic [63:0] stripe;
    logic [63:0] span;
    int subs;
    int dones;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 7) begin
        w = random_word();
        if ($urandom_range(0, 4) == 0) w.block_shift = 5'($urandom_range(13, 31));
        else w.block_shift = 5'($urandom_range(0, 12));
        if ($urandom_range(0, 1) == 1) w.range_offset = 48'($urandom_range(0, 1 << 20));
        stripe = 64'(cur_blocks) << w.block_shift;
        if ($urandom_range(0, 3) == 0) subs = $urandom_range(1, cur_win + 3);
        else subs = $urandom_range(1, 4);
        span = stripe * 64'(subs) - ({32'd0, $urandom} % stripe);
        if (span > OFF_LIMIT) span = 64'(48'({$urandom, $urandom}));
        w.range_length = span[wrs_pkg::OFF_W-1:0];
        send_word(w);
        sent++;
        dones = subs + $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0) dones = $urandom_range(0, subs - 1);
        repeat (dones) begin
          w = random_word();
          w.action = wrs_pkg::ACT_DONE;
          send_word(w);
          sent++;
        end
      end else begin
        w = random_word();
        case ($urandom_range(0, 3))
          0: w.action = wrs_pkg::ACT_DONE;
          1: w.action = wrs_pkg::ACT_ABORT;
          2: w.action = wrs_pkg::ACT_SPARE;
          default: begin
            if ($urandom_range(0, 1) == 1) w.range_length = '0;
          end
        endcase
        send_word(w);
        if (w.action != wrs_pkg::ACT_SPARE) sent++;
      end
    end
  endtask

  initial begin
    logic [wrs_pkg::NODE_W-1:0] node_a;
    node_a = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_ABORT, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_SPARE, '1, '1, '1, '1, 1'b1));
    send_word(make_word(wrs_pkg::ACT_START, node_a, 48'h1234, '0, 5'd3, 1'b1));
    send_word(make_word(wrs_pkg::ACT_START, '1, '0, 48'd1, '0, 1'b1));
    send_word(make_word(wrs_pkg::ACT_DONE, node_a, '1, '1, '1, 1'b1));
    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_START, '0, 48'd1000, 48'd1573641, 5'd9, 1'b0));
    repeat (4) send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_START, node_a, '0, '1, 5'd31, 1'b1));
    send_word(make_word(wrs_pkg::ACT_START, ~node_a, '1, 48'd5, 5'd0, 1'b1));
    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_START, node_a, 48'h8000_0000_3039, '1, 5'd20, 1'b0));
    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_ABORT, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    send_word(make_word(wrs_pkg::ACT_START, ~node_a, 48'({$urandom, $urandom}), 48'd3000,
                        5'd25, 1'b1));
    send_word(make_word(wrs_pkg::ACT_DONE, '0, '0, '0, '0, 1'b0));
    close_phase();

    write_setting(32'd1, 32'd1);
    random_jobs(10);
    close_phase();

    write_setting(32'd0, 32'd0);
    random_jobs(10);
    close_phase();

    squeeze <= 1'b1;
    write_setting(wrs_pkg::MAX_BLOCKS, wrs_pkg::MAX_WINDOW);
    random_jobs(10);
    close_phase();

    write_setting(32'h1FFFF, 32'h3F);
    random_jobs(10);
    close_phase();

    write_setting($urandom_range(1, 2000), $urandom_range(1, wrs_pkg::MAX_WINDOW));
    random_jobs(10);
    close_phase();

    write_setting($urandom, $urandom);
    random_jobs(10);
    close_phase();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
